>>> design/gda_pkg.sv
// Shared constants, types and calendar functions for the date arithmetic block.
package gda_pkg;

	// Default field widths
	localparam int YEAR_BITS_DEF   = 16;
	localparam int OFFSET_BITS_DEF = 21;
	localparam int DIFF_BITS       = 26;
	localparam int MONTH_BITS      = 4;
	localparam int DAY_BITS        = 5;

	// Calendar constants
	localparam int CYCLE_YEARS   = 400;
	localparam int CENTURY_YEARS = 100;
	localparam int CYCLE_DAYS    = 146097;
	localparam int CENT0_DAYS    = 36525;
	localparam int CENT_DAYS     = 36524;
	localparam int QUAD_DAYS     = 1461;
	localparam int LEAP_DAYS     = 366;
	localparam int YEAR_DAYS     = 365;
	localparam int QUAD_Q_BITS   = 5;

	// Month codes
	localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

	// Request codes
	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_DIFF = 1'b1;

	typedef struct packed {
		logic idle;
		logic done;
	} gda_stat_t;

	typedef struct packed {
		logic month_error;
		logic range_error;
	} gda_flags_t;

	// Days in years 0 .. y-1, year 0 is a leap year (elaboration only)
	function automatic longint days_before_year(input longint y);
		return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	// Day of year (from 0) on which month m starts
	function automatic logic [8:0] month_start(input logic [MONTH_BITS-1:0] m, input logic leap);
		logic [8:0] base;
		unique case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + 9'(leap && (m > MONTH_FEB));
	endfunction

endpackage

>>> design/gda_if.sv
// Request and result channel interfaces of the date arithmetic block.
interface gda_req_if import gda_pkg::*; #(
	parameter int YEAR_BITS   = YEAR_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [YEAR_BITS-1:0]          year_a;
	logic [MONTH_BITS-1:0]         month_a;
	logic [DAY_BITS-1:0]           day_a;
	logic [YEAR_BITS-1:0]          year_b;
	logic [MONTH_BITS-1:0]         month_b;
	logic [DAY_BITS-1:0]           day_b;
	logic signed [OFFSET_BITS-1:0] day_offset;

	modport source (
		output valid, req_type, year_a, month_a, day_a, year_b, month_b, day_b, day_offset,
		input  ready
	);
	modport sink (
		input  valid, req_type, year_a, month_a, day_a, year_b, month_b, day_b, day_offset,
		output ready
	);
endinterface

interface gda_res_if import gda_pkg::*; #(
	parameter int YEAR_BITS = YEAR_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [YEAR_BITS-1:0]        year_out;
	logic [MONTH_BITS-1:0]       month_out;
	logic [DAY_BITS-1:0]         day_out;
	logic signed [DIFF_BITS-1:0] day_difference;
	logic                        month_error;
	logic                        range_error;

	modport source (
		output valid, year_out, month_out, day_out, day_difference, month_error, range_error,
		input  ready
	);
	modport sink (
		input  valid, year_out, month_out, day_out, day_difference, month_error, range_error,
		output ready
	);
endinterface

>>> design/gda_addsub.sv
// Shared add/subtract unit with sign flag, used by every step of the sequencer.
module gda_addsub import gda_pkg::*; #(
	parameter int W = DIFF_BITS + 1
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] sum,
	output logic         neg
);

	// Two's complement add, invert and carry in for subtract
	assign sum = a + (b ^ {W{sub}}) + W'(sub);
	assign neg = sum[W-1];

endmodule

>>> design/gda_core.sv
// Sequencer and registers that drive the shared adder through day count and date steps.
module gda_core import gda_pkg::*; #(
	parameter int YEAR_BITS   = YEAR_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          req_type,
	input  logic [YEAR_BITS-1:0]          year_a,
	input  logic [MONTH_BITS-1:0]         month_a,
	input  logic [DAY_BITS-1:0]           day_a,
	input  logic [YEAR_BITS-1:0]          year_b,
	input  logic [MONTH_BITS-1:0]         month_b,
	input  logic [DAY_BITS-1:0]           day_b,
	input  logic signed [OFFSET_BITS-1:0] day_offset,
	input  logic                          take,
	output gda_stat_t                     stat,
	output logic [YEAR_BITS-1:0]          year_out,
	output logic [MONTH_BITS-1:0]         month_out,
	output logic [DAY_BITS-1:0]           day_out,
	output logic [DIFF_BITS-1:0]          day_difference,
	output gda_flags_t                    flags
);

	localparam int QW     = YEAR_BITS - 6;
	localparam int CW     = $clog2(QW > QUAD_Q_BITS ? QW : QUAD_Q_BITS);
	localparam int ACC_Y  = YEAR_BITS + 12;
	localparam int ACC_O  = OFFSET_BITS + 2;
	localparam int ACC_YO = ACC_Y > ACC_O ? ACC_Y : ACC_O;
	localparam int ACC_W  = ACC_YO > DIFF_BITS + 1 ? ACC_YO : DIFF_BITS + 1;

	localparam longint LIMIT  = days_before_year(longint'(1) << YEAR_BITS);
	localparam longint DIVY0  = longint'(CYCLE_YEARS) << (QW - 1);
	localparam longint DIVZ0  = longint'(CYCLE_DAYS) << (QW - 1);
	localparam longint DIVG0  = longint'(QUAD_DAYS) << (QUAD_Q_BITS - 1);

	typedef enum logic [17:0] {
		S_IDLE = 18'h00001,
		S_YDIV = 18'h00002,
		S_C365 = 18'h00004,
		S_C4   = 18'h00008,
		S_CQ1  = 18'h00010,
		S_CQ2  = 18'h00020,
		S_CSM  = 18'h00040,
		S_DEC  = 18'h00080,
		S_CHK  = 18'h00100,
		S_ZDIV = 18'h00200,
		S_CENT = 18'h00400,
		S_PRET = 18'h00800,
		S_GDIV = 18'h01000,
		S_YRS  = 18'h02000,
		S_FIXD = 18'h04000,
		S_YR1  = 18'h08000,
		S_YR2  = 18'h10000,
		S_DONE = 18'h20000
	} gda_state_t;

	gda_state_t              state_q;
	logic [ACC_W-1:0]        acc_q;
	logic [ACC_W-1:0]        rem_q;
	logic [ACC_W-1:0]        div_q;
	logic [QW-1:0]           quo_q;
	logic [QUAD_Q_BITS-1:0]  g_q;
	logic [1:0]              c_q;
	logic [1:0]              yi_q;
	logic [CW-1:0]           cnt_q;
	logic                    pass_q;
	logic                    req_q;
	logic [YEAR_BITS-1:0]    year_q;
	logic [MONTH_BITS-1:0]   mon_q;
	logic [DAY_BITS-1:0]     day_q;
	logic [YEAR_BITS-1:0]    yb_q;
	logic [MONTH_BITS-1:0]   mb_q;
	logic [DAY_BITS-1:0]     db_q;
	logic [YEAR_BITS-1:0]    year_out_q;
	logic [MONTH_BITS-1:0]   month_out_q;
	logic [DAY_BITS-1:0]     day_out_q;
	logic [DIFF_BITS-1:0]    diff_q;
	gda_flags_t              flags_q;

	logic [ACC_W-1:0]        op_a;
	logic [ACC_W-1:0]        op_b;
	logic                    op_sub;
	logic [ACC_W-1:0]        alu_sum;
	logic                    alu_neg;

	logic [8:0]              r9;
	logic                    leap_in;
	logic [1:0]              kcnt;
	logic [10:0]             small_pos;
	logic [ACC_W-1:0]        small_v;
	logic [8:0]              ncyc;
	logic [8:0]              doy;
	logic                    leap_out;
	logic [MONTH_BITS-1:0]   mon_sel;
	logic [8:0]              day_sel;
	logic                    ma_bad;
	logic                    mb_bad;

	// Shared arithmetic unit
	gda_addsub #(.W(ACC_W)) u_addsub (
		.a   (op_a),
		.b   (op_b),
		.sub (op_sub),
		.sum (alu_sum),
		.neg (alu_neg)
	);

	// Month and day term of a day count: r9 is the year modulo 400
	always_comb begin
		r9        = rem_q[8:0];
		leap_in   = (r9[1:0] == 2'b00) && (r9 != 9'd100) && (r9 != 9'd200) && (r9 != 9'd300);
		kcnt      = 2'(r9 > 9'd100) + 2'(r9 > 9'd200) + 2'(r9 > 9'd300);
		small_pos = 11'(month_start(mon_q, leap_in)) + 11'(day_q) + 11'(|year_q[1:0]);
		small_v   = ACC_W'(small_pos) - ACC_W'(kcnt);
		ncyc      = 9'(c_q * 7'd100) + {2'b00, g_q, 2'b00} + 9'(yi_q);
	end

	// Month and day from the day of year
	always_comb begin
		doy      = rem_q[8:0];
		leap_out = (yi_q == 2'd0) && ((c_q == 2'd0) || (g_q != '0));
		mon_sel  = MONTH_JAN;
		for (int j = 2; j <= 12; j++) begin
			if (doy >= month_start(MONTH_BITS'(j), leap_out)) begin
				mon_sel = MONTH_BITS'(j);
			end
		end
		day_sel = doy - month_start(mon_sel, leap_out) + 9'd1;
	end

	// Operand selection for the shared adder
	always_comb begin
		op_a   = acc_q;
		op_b   = '0;
		op_sub = 1'b0;
		unique case (state_q)
			S_YDIV, S_ZDIV, S_GDIV: begin
				op_a   = rem_q;
				op_b   = div_q;
				op_sub = 1'b1;
			end
			S_C365: begin
				op_b   = ACC_W'(year_q) * ACC_W'(YEAR_DAYS);
				op_sub = pass_q;
			end
			S_C4: begin
				op_b   = ACC_W'(year_q >> 2);
				op_sub = pass_q;
			end
			S_CQ1: begin
				op_b   = ACC_W'(quo_q);
				op_sub = !pass_q;
			end
			S_CQ2: begin
				op_b   = ACC_W'({quo_q, 1'b0});
				op_sub = !pass_q;
			end
			S_CSM: begin
				op_b   = small_v;
				op_sub = pass_q;
			end
			S_DEC: begin
				op_b   = ACC_W'(1);
				op_sub = 1'b1;
			end
			S_CHK: begin
				op_b   = ACC_W'(LIMIT);
				op_sub = 1'b1;
			end
			S_CENT: begin
				op_a   = rem_q;
				op_b   = (c_q == 2'd0) ? ACC_W'(CENT0_DAYS) : ACC_W'(CENT_DAYS);
				op_sub = 1'b1;
			end
			S_PRET: begin
				op_a   = rem_q;
				op_b   = ACC_W'(1);
			end
			S_YRS: begin
				op_a   = rem_q;
				op_b   = (yi_q == 2'd0) ? ACC_W'(LEAP_DAYS) : ACC_W'(YEAR_DAYS);
				op_sub = 1'b1;
			end
			S_FIXD: begin
				op_a   = rem_q;
				op_b   = ACC_W'(1);
				op_sub = 1'b1;
			end
			S_YR1: begin
				op_a   = '0;
				op_b   = ACC_W'(quo_q) * ACC_W'(CYCLE_YEARS);
			end
			S_YR2: begin
				op_b   = ACC_W'(ncyc);
			end
			default: begin
				op_a   = acc_q;
			end
		endcase
	end

	assign ma_bad = (month_a < MONTH_JAN) || (month_a > MONTH_DEC);
	assign mb_bad = (month_b < MONTH_JAN) || (month_b > MONTH_DEC);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (ma_bad || ((req_type == REQ_DIFF) && mb_bad)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_YDIV;
						end
					end
				end
				S_YDIV: if (cnt_q == '0) state_q <= S_C365;
				S_C365: state_q <= S_C4;
				S_C4:   state_q <= S_CQ1;
				S_CQ1:  state_q <= S_CQ2;
				S_CQ2:  state_q <= S_CSM;
				S_CSM: begin
					if (req_q == REQ_ADD) begin
						state_q <= S_DEC;
					end else if (!pass_q) begin
						state_q <= S_YDIV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DEC: state_q <= S_CHK;
				S_CHK: begin
					if (acc_q[ACC_W-1] || !alu_neg) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_ZDIV;
					end
				end
				S_ZDIV: if (cnt_q == '0) state_q <= S_CENT;
				S_CENT: if ((c_q == 2'd3) || alu_neg) state_q <= S_PRET;
				S_PRET: state_q <= S_GDIV;
				S_GDIV: if (cnt_q == '0) state_q <= S_YRS;
				S_YRS:  if ((yi_q == 2'd3) || alu_neg) state_q <= S_FIXD;
				S_FIXD: state_q <= S_YR1;
				S_YR1:  state_q <= S_YR2;
				S_YR2:  state_q <= S_DONE;
				S_DONE: if (take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q       <= req_type;
					year_q      <= year_a;
					mon_q       <= month_a;
					day_q       <= day_a;
					yb_q        <= year_b;
					mb_q        <= month_b;
					db_q        <= day_b;
					pass_q      <= 1'b0;
					acc_q       <= (req_type == REQ_DIFF) ? '0 :
						{{(ACC_W-OFFSET_BITS){day_offset[OFFSET_BITS-1]}}, day_offset};
					rem_q       <= ACC_W'(year_a);
					div_q       <= ACC_W'(DIVY0);
					cnt_q       <= CW'(QW - 1);
					year_out_q  <= '0;
					month_out_q <= '0;
					day_out_q   <= '0;
					diff_q      <= '0;
					flags_q.month_error <= ma_bad || ((req_type == REQ_DIFF) && mb_bad);
					flags_q.range_error <= 1'b0;
				end
			end
			// Restoring division steps: keep the remainder when the trial stays non-negative
			S_YDIV, S_ZDIV, S_GDIV: begin
				if (!alu_neg) begin
					rem_q <= alu_sum;
				end
				div_q <= div_q >> 1;
				cnt_q <= cnt_q - CW'(1);
				if (state_q == S_GDIV) begin
					g_q <= {g_q[QUAD_Q_BITS-2:0], !alu_neg};
				end else begin
					quo_q <= {quo_q[QW-2:0], !alu_neg};
				end
				if (state_q == S_ZDIV) begin
					c_q <= 2'd0;
				end
			end
			S_C365, S_C4, S_CQ1, S_CQ2, S_DEC, S_YR1: begin
				acc_q <= alu_sum;
			end
			S_CSM: begin
				acc_q <= alu_sum;
				if ((req_q == REQ_DIFF) && !pass_q) begin
					pass_q <= 1'b1;
					year_q <= yb_q;
					mon_q  <= mb_q;
					day_q  <= db_q;
					rem_q  <= ACC_W'(yb_q);
					div_q  <= ACC_W'(DIVY0);
					cnt_q  <= CW'(QW - 1);
				end else if (req_q == REQ_DIFF) begin
					diff_q <= alu_sum[DIFF_BITS-1:0];
				end
			end
			S_CHK: begin
				if (acc_q[ACC_W-1] || !alu_neg) begin
					flags_q.range_error <= 1'b1;
				end
				rem_q <= acc_q;
				div_q <= ACC_W'(DIVZ0);
				cnt_q <= CW'(QW - 1);
			end
			S_CENT: begin
				if ((c_q != 2'd3) && !alu_neg) begin
					rem_q <= alu_sum;
					c_q   <= c_q + 2'd1;
				end
			end
			// Later centuries start one day short: shift them onto a leap start
			S_PRET: begin
				if (c_q != 2'd0) begin
					rem_q <= alu_sum;
				end
				div_q <= ACC_W'(DIVG0);
				cnt_q <= CW'(QUAD_Q_BITS - 1);
				yi_q  <= 2'd0;
			end
			S_YRS: begin
				if ((yi_q != 2'd3) && !alu_neg) begin
					rem_q <= alu_sum;
					yi_q  <= yi_q + 2'd1;
				end
			end
			// Undo the shift inside the first year of a later century
			S_FIXD: begin
				if ((c_q != 2'd0) && (g_q == '0) && (yi_q == 2'd0)) begin
					rem_q <= alu_sum;
				end
			end
			S_YR2: begin
				year_out_q  <= alu_sum[YEAR_BITS-1:0];
				month_out_q <= mon_sel;
				day_out_q   <= day_sel[DAY_BITS-1:0];
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign stat.idle      = (state_q == S_IDLE);
	assign stat.done      = (state_q == S_DONE);
	assign year_out       = year_out_q;
	assign month_out      = month_out_q;
	assign day_out        = day_out_q;
	assign day_difference = diff_q;
	assign flags          = flags_q;

endmodule

>>> design/gregorian_date_arithmetic_top.sv
// One request is worked at a time through the shared adder in the sequencer; for YEAR_BITS = Y,
// two of its divisions by shift and subtract take Y - 6 steps each, and a bad month skips them.
// The next request is taken while a result beat waits in the output register.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and empties the output.
module gregorian_date_arithmetic_top import gda_pkg::*; #(
	parameter int YEAR_BITS   = YEAR_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	gda_req_if.sink req,
	gda_res_if.source res
);

	gda_stat_t             stat;
	gda_flags_t            flags;
	logic                  start;
	logic                  load;
	logic                  out_valid_q;
	logic [YEAR_BITS-1:0]  year_c;
	logic [MONTH_BITS-1:0] month_c;
	logic [DAY_BITS-1:0]   day_c;
	logic [DIFF_BITS-1:0]  diff_c;
	logic [YEAR_BITS-1:0]  year_q;
	logic [MONTH_BITS-1:0] month_q;
	logic [DAY_BITS-1:0]   day_q;
	logic [DIFF_BITS-1:0]  diff_q;
	gda_flags_t            flags_q;

	// Take a request beat only while the sequencer is idle
	assign req.ready = stat.idle;
	assign start     = req.valid && stat.idle;

	gda_core #(
		.YEAR_BITS   (YEAR_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.req_type       (req.req_type),
		.year_a         (req.year_a),
		.month_a        (req.month_a),
		.day_a          (req.day_a),
		.year_b         (req.year_b),
		.month_b        (req.month_b),
		.day_b          (req.day_b),
		.day_offset     (req.day_offset),
		.take           (load),
		.stat           (stat),
		.year_out       (year_c),
		.month_out      (month_c),
		.day_out        (day_c),
		.day_difference (diff_c),
		.flags          (flags)
	);

	// Move a finished result into the output register when it is free
	assign load = stat.done && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			year_q  <= year_c;
			month_q <= month_c;
			day_q   <= day_c;
			diff_q  <= diff_c;
			flags_q <= flags;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.year_out       = year_q;
	assign res.month_out      = month_q;
	assign res.day_out        = day_q;
	assign res.day_difference = diff_q;
	assign res.month_error    = flags_q.month_error;
	assign res.range_error    = flags_q.range_error;

endmodule

>>> sim/gregorian_date_arithmetic_top_test.sv
// Self-checking testbench for the Gregorian date add and difference block.
module gregorian_date_arithmetic_top_test;
	import gda_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int YB           = YEAR_BITS_DEF;
	localparam int OB           = OFFSET_BITS_DEF;
	localparam int N_DIRECTED   = 24;
	localparam int N_RANDOM     = 1230;
	localparam int N_PHASES     = 4;
	localparam int DRAIN_CYCLES = 2 * YB + 30;
	localparam int STALL_LIMIT  = 3000;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic          req_type;
		logic [YB-1:0] year_a;
		logic [3:0]    month_a;
		logic [4:0]    day_a;
		logic [YB-1:0] year_b;
		logic [3:0]    month_b;
		logic [4:0]    day_b;
		logic [OB-1:0] day_offset;
	} date_req_t;

	typedef struct packed {
		logic [YB-1:0]        year_out;
		logic [3:0]           month_out;
		logic [4:0]           day_out;
		logic [DIFF_BITS-1:0] day_difference;
		logic                 month_error;
		logic                 range_error;
	} date_res_t;

	typedef struct packed {
		date_req_t rq;
		logic      known;
		date_res_t res;
	} stim_row_t;

	localparam date_res_t NO_RES    = '0;
	localparam date_res_t MONTH_BAD = '{default: '0, month_error: 1'b1};
	localparam date_res_t RANGE_BAD = '{default: '0, range_error: 1'b1};

	// Directed rows: known results only for range extremes, error codes and a zero difference
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{'{REQ_ADD, 16'd0, MONTH_JAN, 5'd1, 16'd0, 4'd0, 5'd0, 21'd0}, 1'b1,
			'{16'd0, MONTH_JAN, 5'd1, 26'd0, 1'b0, 1'b0}},
		'{'{REQ_ADD, 16'd0, MONTH_JAN, 5'd1, 16'd0, 4'd0, 5'd0, 21'h1FFFFF}, 1'b1, RANGE_BAD},
		'{'{REQ_ADD, 16'hFFFF, MONTH_DEC, 5'd31, 16'd0, 4'd0, 5'd0, 21'd0}, 1'b1,
			'{16'hFFFF, MONTH_DEC, 5'd31, 26'd0, 1'b0, 1'b0}},
		'{'{REQ_ADD, 16'hFFFF, MONTH_DEC, 5'd31, 16'd0, 4'd0, 5'd0, 21'd1}, 1'b1, RANGE_BAD},
		'{'{REQ_ADD, 16'd2000, 4'd0, 5'd10, 16'd0, 4'd0, 5'd0, 21'd5}, 1'b1, MONTH_BAD},
		'{'{REQ_ADD, 16'd2000, 4'd13, 5'd10, 16'd0, 4'd0, 5'd0, 21'd5}, 1'b1, MONTH_BAD},
		'{'{REQ_ADD, 16'd2000, 4'd15, 5'd31, 16'd0, 4'd0, 5'd0, 21'h1FFFFF}, 1'b1, MONTH_BAD},
		'{'{REQ_DIFF, 16'd2000, MONTH_JAN, 5'd1, 16'd2000, 4'd0, 5'd1, 21'd0}, 1'b1, MONTH_BAD},
		'{'{REQ_DIFF, 16'd2000, 4'd14, 5'd1, 16'd2000, 4'd5, 5'd1, 21'd0}, 1'b1, MONTH_BAD},
		'{'{REQ_DIFF, 16'd1999, 4'd7, 5'd4, 16'd1999, 4'd7, 5'd4, 21'd0}, 1'b1, NO_RES},
		'{'{REQ_DIFF, 16'd0, MONTH_JAN, 5'd1, 16'hFFFF, MONTH_DEC, 5'd31, 21'd0}, 1'b0, NO_RES},
		'{'{REQ_DIFF, 16'hFFFF, MONTH_DEC, 5'd31, 16'd0, MONTH_JAN, 5'd1, 21'd0}, 1'b0, NO_RES},
		'{'{REQ_ADD, 16'd2000, MONTH_JAN, 5'd1, 16'd0, 4'd0, 5'd0, 21'h0FFFFF}, 1'b0, NO_RES},
		'{'{REQ_ADD, 16'd5000, 4'd6, 5'd15, 16'd0, 4'd0, 5'd0, 21'h100000}, 1'b0, NO_RES},
		'{'{REQ_ADD, 16'd1900, MONTH_FEB, 5'd28, 16'd0, 4'd0, 5'd0, 21'd1}, 1'b0, NO_RES},
		'{'{REQ_ADD, 16'd2000, MONTH_FEB, 5'd28, 16'd0, 4'd0, 5'd0, 21'd1}, 1'b0, NO_RES},
		'{'{REQ_ADD, 16'd0, MONTH_FEB, 5'd29, 16'd0, 4'd0, 5'd0, 21'd1}, 1'b0, NO_RES},
		'{'{REQ_ADD, 16'd2023, 4'd3, 5'd0, 16'd0, 4'd0, 5'd0, 21'd0}, 1'b0, NO_RES},
		'{'{REQ_ADD, 16'd2023, 4'd4, 5'd31, 16'd0, 4'd0, 5'd0, 21'd0}, 1'b0, NO_RES},
		'{'{REQ_ADD, 16'd2024, MONTH_DEC, 5'd31, 16'd0, 4'd0, 5'd0, 21'd1}, 1'b0, NO_RES},
		'{'{REQ_ADD, 16'd2024, MONTH_JAN, 5'd1, 16'd0, 4'd0, 5'd0, 21'h1FFFFF}, 1'b0, NO_RES},
		'{'{REQ_DIFF, 16'd2000, 4'd3, 5'd1, 16'd2000, MONTH_FEB, 5'd28, 21'd0}, 1'b0, NO_RES},
		'{'{REQ_ADD, 16'd65000, MONTH_JAN, 5'd1, 16'd0, 4'd0, 5'd0, 21'h0FFFFF}, 1'b1, RANGE_BAD},
		'{'{REQ_ADD, 16'd100, MONTH_JAN, 5'd1, 16'd0, 4'd0, 5'd0, 21'h100000}, 1'b1, RANGE_BAD}
	};

	logic clk;
	logic arst_n;

	gda_req_if #(.YEAR_BITS(YB), .OFFSET_BITS(OB)) req_if ();
	gda_res_if #(.YEAR_BITS(YB)) res_if ();

	gregorian_date_arithmetic_top #(.YEAR_BITS(YB), .OFFSET_BITS(OB)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.res    (res_if.source)
	);

	stim_row_t   stim_q [$];
	date_res_t   expected_q [$];
	int          total_items;
	int          accepted;
	int          mismatches;
	int          idle_cycles;
	int          n_add;
	int          n_diff;
	int          n_month_err;
	int          n_range_err;

	// Calendar helpers for the date predictor
	function automatic bit leap_year(longint y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int month_days(int m, bit lp);
		case (m)
			4, 6, 9, 11: return 30;
			MONTH_FEB:   return lp ? 29 : 28;
			default:     return 31;
		endcase
	endfunction

	// Days in all years strictly before y; year zero is leap
	function automatic longint days_to_jan1(longint y);
		if (y == 0)
			return 0;
		return 365 * y + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
	endfunction

	function automatic longint ordinal_day(longint y, int m, longint d);
		longint t;
		t = days_to_jan1(y);
		for (int k = 1; k < m; k++)
			t += month_days(k, leap_year(y));
		return t + d;
	endfunction

	function automatic bit month_ok(logic [3:0] m);
		return (m >= MONTH_JAN) && (m <= MONTH_DEC);
	endfunction

	// Work out the result beat for one request beat
	function automatic date_res_t predict_date(date_req_t r);
		date_res_t o;
		longint    s;
		longint    z;
		longint    y;
		int        m;
		o = '0;
		if (r.req_type == REQ_DIFF) begin
			if (!month_ok(r.month_a) || !month_ok(r.month_b)) begin
				o.month_error = 1'b1;
				return o;
			end
			s = ordinal_day(r.year_a, r.month_a, r.day_a)
				- ordinal_day(r.year_b, r.month_b, r.day_b);
			o.day_difference = DIFF_BITS'(s);
			return o;
		end
		if (!month_ok(r.month_a)) begin
			o.month_error = 1'b1;
			return o;
		end
		s = ordinal_day(r.year_a, r.month_a, r.day_a) + longint'($signed(r.day_offset));
		if (s < 1 || s - 1 >= days_to_jan1(longint'(1) << YB)) begin
			o.range_error = 1'b1;
			return o;
		end
		// Estimate the year, then settle it exactly
		z = s - 1;
		y = z * 400 / CYCLE_DAYS;
		while (y > 0 && days_to_jan1(y) > z)
			y--;
		while (days_to_jan1(y + 1) <= z)
			y++;
		z -= days_to_jan1(y);
		m = 1;
		while (m < 12 && z >= month_days(m, leap_year(y))) begin
			z -= month_days(m, leap_year(y));
			m++;
		end
		o.year_out  = YB'(y);
		o.month_out = 4'(m);
		o.day_out   = 5'(z + 1);
		return o;
	endfunction

	// Random field pickers, biased toward the ends of the year range
	function automatic logic [YB-1:0] pick_year();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 2)
			return YB'($urandom_range(0, 3000));
		if (sel < 4)
			return YB'($urandom_range(62500, 65535));
		return YB'($urandom);
	endfunction

	function automatic logic [3:0] pick_month();
		if ($urandom_range(0, 99) < 92)
			return 4'($urandom_range(1, 12));
		return 4'($urandom);
	endfunction

	function automatic logic [4:0] pick_day(logic [YB-1:0] y, logic [3:0] m);
		if (month_ok(m) && $urandom_range(0, 99) < 85)
			return 5'($urandom_range(1, month_days(m, leap_year(y))));
		return 5'($urandom);
	endfunction

	function automatic date_req_t random_request();
		date_req_t   r;
		int unsigned sel;
		r.req_type = ($urandom_range(0, 99) < 35) ? REQ_DIFF : REQ_ADD;
		r.year_a   = pick_year();
		r.month_a  = pick_month();
		r.day_a    = pick_day(r.year_a, r.month_a);
		if ($urandom_range(0, 99) < 40)
			r.year_b = r.year_a + YB'($urandom_range(0, 6)) - YB'(3);
		else
			r.year_b = pick_year();
		r.month_b = pick_month();
		r.day_b   = pick_day(r.year_b, r.month_b);
		sel = $urandom_range(0, 9);
		if (sel < 4)
			r.day_offset = OB'(int'($urandom_range(0, 800)) - 400);
		else if (sel < 7)
			r.day_offset = OB'(int'($urandom_range(0, 100000)) - 50000);
		else
			r.day_offset = OB'($urandom);
		return r;
	endfunction

	function automatic int phase_of(int n);
		int p;
		p = (total_items == 0) ? 0 : n * N_PHASES / total_items;
		return (p >= N_PHASES) ? N_PHASES - 1 : p;
	endfunction

	// Phases: free-running, sender idle, receiver stall, both
	function automatic int send_idle_pct(int p);
		case (p)
			1:       return 76;
			3:       return 38;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(int p);
		case (p)
			2:       return 76;
			3:       return 38;
			default: return 0;
		endcase
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Drive request beats; hold the payload until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				if (stim_q[0].known)
					expected_q.push_back(stim_q[0].res);
				else
					expected_q.push_back(predict_date(stim_q[0].rq));
				void'(stim_q.pop_front());
				accepted <= accepted + 1;
			end
			if (!req_if.valid || req_if.ready) begin
				if (stim_q.size() > 0 &&
					$urandom_range(0, 99) >= send_idle_pct(phase_of(accepted))) begin
					req_if.valid      <= 1'b1;
					req_if.req_type   <= stim_q[0].rq.req_type;
					req_if.year_a     <= stim_q[0].rq.year_a;
					req_if.month_a    <= stim_q[0].rq.month_a;
					req_if.day_a      <= stim_q[0].rq.day_a;
					req_if.year_b     <= stim_q[0].rq.year_b;
					req_if.month_b    <= stim_q[0].rq.month_b;
					req_if.day_b      <= stim_q[0].rq.day_b;
					req_if.day_offset <= stim_q[0].rq.day_offset;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Take result beats and check them against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		date_res_t got;
		date_res_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got.year_out       = res_if.year_out;
				got.month_out      = res_if.month_out;
				got.day_out        = res_if.day_out;
				got.day_difference = res_if.day_difference;
				got.month_error    = res_if.month_error;
				got.range_error    = res_if.range_error;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result beat with none expected: y=%0d m=%0d d=%0d diff=%0d",
							$realtime, got.year_out, got.month_out, got.day_out,
							$signed(got.day_difference));
				end else begin
					want = expected_q.pop_front();
					if (want.month_error)
						n_month_err++;
					else if (want.range_error)
						n_range_err++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: expected y=%0d m=%0d d=%0d diff=%0d merr=%0b rerr=%0b",
								$realtime, want.year_out, want.month_out, want.day_out,
								$signed(want.day_difference), want.month_error,
								want.range_error);
							$display("%0t: actual   y=%0d m=%0d d=%0d diff=%0d merr=%0b rerr=%0b",
								$realtime, got.year_out, got.month_out, got.day_out,
								$signed(got.day_difference), got.month_error,
								got.range_error);
						end
					end
				end
			end
			res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct(phase_of(accepted)));
		end
	end

	// Watchdog: end the run when no beat moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $realtime, STALL_LIMIT);
				$display("gregorian_date_arithmetic_top: mismatch");
				$finish;
			end
		end
	end

	// Build stimulus, reset, wait for completion, report
	initial begin
		date_req_t r;
		stim_row_t row;
		arst_n            = 1'b0;
		req_if.valid      = 1'b0;
		req_if.req_type   = REQ_ADD;
		req_if.year_a     = '0;
		req_if.month_a    = '0;
		req_if.day_a      = '0;
		req_if.year_b     = '0;
		req_if.month_b    = '0;
		req_if.day_b      = '0;
		req_if.day_offset = '0;
		res_if.ready      = 1'b0;
		accepted          = 0;
		mismatches        = 0;
		idle_cycles       = 0;
		n_add             = 0;
		n_diff            = 0;
		n_month_err       = 0;
		n_range_err       = 0;

		// Walk the directed table, then append random requests
		for (int i = 0; i < N_DIRECTED; i++)
			stim_q.push_back(DIRECTED[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			r = random_request();
			row.rq    = r;
			row.known = 1'b0;
			row.res   = NO_RES;
			stim_q.push_back(row);
		end
		foreach (stim_q[i]) begin
			if (stim_q[i].rq.req_type == REQ_DIFF)
				n_diff++;
			else
				n_add++;
		end
		total_items = stim_q.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests (%0d add, %0d difference) over %0d idling phases;",
			total_items, n_add, n_diff, N_PHASES);
		$display("results included %0d month errors and %0d range errors, %0d mismatches.",
			n_month_err, n_range_err, mismatches);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("gregorian_date_arithmetic_top: match");
		else
			$display("gregorian_date_arithmetic_top: mismatch");
		$finish;
	end

endmodule
